// File: rtl/mmrc_pkg.sv
package mmrc_pkg;

    localparam int unsigned FRAME_LEN   = 41;
    localparam int unsigned N_VAL16     = 9;
    localparam int unsigned N_VAL32     = 3;
    localparam int unsigned N_VALUES    = N_VAL16 + N_VAL32;

    localparam logic [5:0] COUNT_MAX    = 6'd63;
    localparam logic [5:0] LAST_IDX     = 6'(FRAME_LEN - 1);
    localparam logic [5:0] IDX_CRC_FEED = 6'd2;
    localparam logic [5:0] IDX_ADDR     = 6'd0;
    localparam logic [5:0] IDX_FUNC     = 6'd1;
    localparam logic [5:0] IDX_BCOUNT   = 6'd2;
    localparam logic [5:0] IDX_VA_LO    = 6'd3;
    localparam logic [5:0] IDX_VA_HI    = 6'd14;
    localparam logic [5:0] IDX_VB_LO    = 6'd21;
    localparam logic [5:0] IDX_VB_HI    = 6'd26;
    localparam logic [5:0] IDX_VC_LO    = 6'd27;
    localparam logic [5:0] IDX_VC_HI    = 6'd38;
    localparam logic [3:0] VB_BASE      = 4'd6;
    localparam logic [3:0] LAST_VALUE   = 4'(N_VALUES - 1);
    localparam logic [3:0] FIRST_VAL32  = 4'(N_VAL16);

    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  PAYLOAD_LEN = 8'd36;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    localparam int unsigned HDR_ADDR    = 0;
    localparam int unsigned HDR_FUNC    = 1;
    localparam int unsigned HDR_BCOUNT  = 2;

    localparam logic [15:0] CRC_NIB [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LENGTH = 3'd1,
        ST_ADDR   = 3'd2,
        ST_FUNC   = 3'd3,
        ST_BCOUNT = 3'd4,
        ST_CRC    = 3'd5
    } status_t;

    typedef logic [15:0] word16_t;
    typedef logic [31:0] word32_t;

    typedef struct packed {
        logic    fire;
        status_t status;
    } frame_done_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        t = CRC_NIB[b[3:0] ^ c[3:0]] ^ (c >> 4);
        t = CRC_NIB[b[7:4] ^ t[3:0]] ^ (t >> 4);
        return t;
    endfunction

endpackage

// File: rtl/modbus_meter_response_checker_top.sv
// Checks a Modbus RTU read-holding-registers response of 41 bytes, taken one item per cycle
// with frame_end on the last byte. A bad frame gives one result carrying the first failed check
// (length, address, function, byte count, CRC); a good one gives twelve measurements, one per
// cycle while out_ready is high, from the output register, the last flagged by last_result.
// Every byte but the frame_end byte is accepted at once; the frame_end byte waits while the
// output register still has results of the previous frame to deliver, and its wait grows
// while out_ready is low. Results of a passing frame are copied out at frame end, so the
// next frame streams in while they drain. slave_address resets to 1 and is sampled as
// byte 0 arrives.
module modbus_meter_response_checker_top
    import mmrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  value_index,
    output logic [31:0] value,
    output logic        last_result
);

    logic [7:0]  slave_address_reg;
    logic        accept;
    logic        can_load;
    frame_done_t done;
    word16_t     val16 [N_VAL16];
    word32_t     val32 [N_VAL32];

    assign in_ready = !frame_end || can_load;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
        end
        else if (cfg_write)
        begin
            slave_address_reg <= cfg_data;
        end
    end

    mmrc_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .slave_address (slave_address_reg),
        .done          (done),
        .val16         (val16),
        .val32         (val32)
    );

    mmrc_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .done        (done),
        .val16       (val16),
        .val32       (val32),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_index (value_index),
        .value       (value),
        .last_result (last_result)
    );

endmodule

// File: rtl/mmrc_frame.sv
module mmrc_frame
    import mmrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic [7:0]  slave_address,
    output frame_done_t done,
    output word16_t     val16 [N_VAL16],
    output word32_t     val32 [N_VAL32]
);

    logic [5:0]  count_reg;
    logic [15:0] crc_reg;
    logic [15:0] held_reg;
    logic [2:0]  hdr_reg;
    word16_t     val16_reg [N_VAL16];
    word32_t     val32_reg [N_VAL32];

    logic [15:0] crc_next;
    logic [2:0]  hdr_next;
    logic [5:0]  off_a;
    logic [5:0]  off_b;
    logic [5:0]  off_c;
    logic        wr16;
    logic        wr32;
    logic [3:0]  sel16;
    logic [1:0]  sel32;
    status_t     status;

    always_comb
    begin
        crc_next = (count_reg >= IDX_CRC_FEED) ? crc_feed(crc_reg, held_reg[15:8]) : crc_reg;
        hdr_next = hdr_reg;
        if (count_reg == IDX_ADDR && rx_byte != slave_address)
        begin
            hdr_next[HDR_ADDR] = 1'b1;
        end
        if (count_reg == IDX_FUNC && rx_byte != FUNC_READ)
        begin
            hdr_next[HDR_FUNC] = 1'b1;
        end
        if (count_reg == IDX_BCOUNT && rx_byte != PAYLOAD_LEN)
        begin
            hdr_next[HDR_BCOUNT] = 1'b1;
        end
    end

    always_comb
    begin
        off_a = count_reg - IDX_VA_LO;
        off_b = count_reg - IDX_VB_LO;
        off_c = count_reg - IDX_VC_LO;
        wr16  = 1'b0;
        wr32  = 1'b0;
        sel16 = '0;
        sel32 = '0;
        if (count_reg inside {[IDX_VA_LO:IDX_VA_HI]})
        begin
            wr16  = 1'b1;
            sel16 = off_a[4:1];
        end
        else if (count_reg inside {[IDX_VB_LO:IDX_VB_HI]})
        begin
            wr16  = 1'b1;
            sel16 = VB_BASE + {2'b00, off_b[2:1]};
        end
        else if (count_reg inside {[IDX_VC_LO:IDX_VC_HI]})
        begin
            wr32  = 1'b1;
            sel32 = off_c[3:2];
        end
    end

    always_comb
    begin
        if (count_reg != LAST_IDX)
        begin
            status = ST_LENGTH;
        end
        else if (hdr_next[HDR_ADDR])
        begin
            status = ST_ADDR;
        end
        else if (hdr_next[HDR_FUNC])
        begin
            status = ST_FUNC;
        end
        else if (hdr_next[HDR_BCOUNT])
        begin
            status = ST_BCOUNT;
        end
        else if (crc_next != {rx_byte, held_reg[7:0]})
        begin
            status = ST_CRC;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign done.fire   = accept && frame_end;
    assign done.status = status;
    assign val16       = val16_reg;
    assign val32       = val32_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            held_reg  <= '0;
            hdr_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                count_reg <= '0;
                crc_reg   <= CRC_INIT;
                held_reg  <= '0;
                hdr_reg   <= '0;
            end
            else
            begin
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 6'd1;
                end
                crc_reg  <= crc_next;
                held_reg <= {held_reg[7:0], rx_byte};
                hdr_reg  <= hdr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr16)
        begin
            val16_reg[sel16] <= {val16_reg[sel16][7:0], rx_byte};
        end
        if (accept && wr32)
        begin
            val32_reg[sel32] <= {val32_reg[sel32][23:0], rx_byte};
        end
    end

endmodule

// File: rtl/mmrc_emit.sv
module mmrc_emit
    import mmrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_done_t done,
    input  word16_t     val16 [N_VAL16],
    input  word32_t     val32 [N_VAL32],
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  value_index,
    output logic [31:0] value,
    output logic        last_result
);

    logic        valid_reg;
    status_t     status_reg;
    logic [3:0]  index_reg;
    logic [31:0] value_reg;
    logic        last_reg;
    word16_t     sh16_reg [N_VAL16];
    word32_t     sh32_reg [N_VAL32];

    logic [3:0]  index_next;
    logic [3:0]  off32;
    logic [31:0] value_next;
    logic        advance;
    logic        taken;

    assign taken    = valid_reg && out_ready;
    assign can_load = !valid_reg || (out_ready && last_reg);
    assign advance  = taken && !last_reg;

    always_comb
    begin
        index_next = index_reg + 4'd1;
        off32      = index_next - FIRST_VAL32;
        if (index_next < FIRST_VAL32)
        begin
            value_next = {16'h0000, sh16_reg[index_next]};
        end
        else
        begin
            value_next = sh32_reg[off32[1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            index_reg <= '0;
        end
        else if (done.fire)
        begin
            valid_reg <= 1'b1;
            index_reg <= '0;
            last_reg  <= (done.status != ST_OK);
        end
        else if (advance)
        begin
            index_reg <= index_next;
            last_reg  <= (index_next == LAST_VALUE);
        end
        else if (taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.fire)
        begin
            status_reg <= done.status;
            value_reg  <= (done.status == ST_OK) ? {16'h0000, val16[0]} : 32'd0;
            sh16_reg   <= val16;
            sh32_reg   <= val32;
        end
        else if (advance)
        begin
            value_reg <= value_next;
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign value_index = index_reg;
    assign value       = value_reg;
    assign last_result = last_reg;

endmodule

// File: rtl/mmrc_checker.sv
module mmrc_checker
    import mmrc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [3:0]  value_index,
    input logic [31:0] value,
    input logic        last_result
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_index) && $stable(value)
            && $stable(status) && $stable(last_result))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last_result && value_index == 4'd0 && value == 32'd0)
    else $error("error result malformed");

    // advance the burst by one value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> out_valid && status == ST_OK
            && value_index == $past(value_index) + 4'd1)
    else $error("burst did not advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && value_index == LAST_VALUE |-> last_result)
    else $error("final value not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && last_result |-> value_index == LAST_VALUE)
    else $error("burst ended early");

endmodule

bind modbus_meter_response_checker_top mmrc_checker u_mmrc_checker (.*);

// File: verif/modbus_meter_response_checker_top_tb.sv
module modbus_meter_response_checker_top_tb;
    import mmrc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_PCT     = 21;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 20;
    localparam int REPORT_MAX   = 10;
    localparam int N_PAYLOAD    = 36;
    localparam int PHASE_ITEMS  = 30;
    localparam int WRAP_LEN     = 105;

    typedef struct packed {
        status_t     status;
        logic [3:0]  index;
        logic [31:0] val;
        logic        last;
    } reading_t;

    class meter_scoreboard;
        logic [7:0]  slave_addr;
        logic [5:0]  byte_cnt;
        logic [15:0] crc;
        logic [15:0] held;
        logic [2:0]  hdr_err;
        logic [7:0]  payload [N_PAYLOAD];
        reading_t    readings_q [$];
        int          mismatches;

        function new();
            slave_addr = 8'd1;
            mismatches = 0;
            foreach (payload[i])
                payload[i] = 8'h00;
            clear_frame();
        endfunction

        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            c = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            return c;
        endfunction

        function void clear_frame();
            byte_cnt = 6'd0;
            crc      = CRC_INIT;
            held     = 16'h0000;
            hdr_err  = 3'b000;
        endfunction

        function void set_address(logic [7:0] a);
            slave_addr = a;
        endfunction

        function int pending();
            return readings_q.size();
        endfunction

        function logic [31:0] be16(int off);
            return {16'h0000, payload[off], payload[off + 1]};
        endfunction

        function logic [31:0] be32(int off);
            return {payload[off], payload[off + 1], payload[off + 2], payload[off + 3]};
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int       idx;
            status_t  st;
            reading_t r;
            idx = byte_cnt;
            if (idx >= 2)
                crc = crc_step(crc, held[15:8]);
            if (idx == 0 && b != slave_addr)
                hdr_err[HDR_ADDR] = 1'b1;
            if (idx == 1 && b != FUNC_READ)
                hdr_err[HDR_FUNC] = 1'b1;
            if (idx == 2 && b != PAYLOAD_LEN)
                hdr_err[HDR_BCOUNT] = 1'b1;
            if (idx >= 3 && idx < 3 + N_PAYLOAD)
                payload[idx - 3] = b;
            if (!last)
            begin
                held = {held[7:0], b};
                if (byte_cnt != COUNT_MAX)
                    byte_cnt = byte_cnt + 6'd1;
                return;
            end
            st = ST_OK;
            if (idx != FRAME_LEN - 1)
                st = ST_LENGTH;
            else if (hdr_err[HDR_ADDR])
                st = ST_ADDR;
            else if (hdr_err[HDR_FUNC])
                st = ST_FUNC;
            else if (hdr_err[HDR_BCOUNT])
                st = ST_BCOUNT;
            else if (crc != {b, held[7:0]})
                st = ST_CRC;
            clear_frame();
            if (st != ST_OK)
            begin
                r.status = st;
                r.index  = 4'd0;
                r.val    = 32'd0;
                r.last   = 1'b1;
                readings_q.push_back(r);
                return;
            end
            for (int k = 0; k < 12; k++)
            begin
                r.status = ST_OK;
                r.index  = 4'(k);
                if (k < 6)
                    r.val = be16(2 * k);
                else if (k < 9)
                    r.val = be16(2 * k + 6);
                else
                    r.val = be32(24 + 4 * (k - 9));
                r.last = (k == 11);
                readings_q.push_back(r);
            end
        endfunction

        function void report(string what, reading_t want, reading_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display({"%s: expected status %0d index %0d value %h last %0b,",
                          " got status %0d index %0d value %h last %0b"},
                         what, want.status, want.index, want.val, want.last,
                         got.status, got.index, got.val, got.last);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (readings_q.size() == 0)
            begin
                want = '0;
                report("unexpected result", want, got);
                return;
            end
            want = readings_q.pop_front();
            if (want !== got)
                report("reading mismatch", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [3:0]  value_index;
    logic [31:0] value;
    logic        last_result;

    meter_scoreboard sb;
    logic [7:0]      frame_q [$];
    logic [7:0]      cur_addr;
    logic            calm = 1'b0;
    int              stall_cycles;

    modbus_meter_response_checker_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_index (value_index),
        .value       (value),
        .last_result (last_result)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : monitor
        reading_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.status = status_t'(status);
                got.index  = value_index;
                got.val    = value;
                got.last   = last_result;
                sb.check_reading(got);
            end
            if (in_valid && in_ready)
                sb.note_byte(rx_byte, frame_end);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("modbus_meter_response_checker_top_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_frame(inout int sent);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        sent += frame_q.size();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_address(input logic [7:0] a);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_address(a);
        cur_addr = a;
    endtask

    // fill below zero gives random payload bytes
    function automatic void build_body(input int fill);
        frame_q = {};
        frame_q.push_back(cur_addr);
        frame_q.push_back(FUNC_READ);
        frame_q.push_back(PAYLOAD_LEN);
        for (int i = 0; i < N_PAYLOAD; i++)
            frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endfunction

    function automatic void append_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i])
            c = meter_scoreboard::crc_step(c, frame_q[i]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endfunction

    function automatic void build_good(input int fill);
        build_body(fill);
        append_crc();
    endfunction

    initial
    begin
        int         sent;
        int         kind;
        int         pos;
        int         len;
        logic [7:0] phase_addr [4];
        sb        = new();
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 8'h00;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        frame_end = 1'b0;
        cur_addr  = 8'd1;
        sent      = 0;
        stall_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_good(-1);
        send_frame(sent);
        frame_q = '{8'hFF};
        send_frame(sent);
        frame_q = '{cur_addr, FUNC_READ};
        send_frame(sent);
        // long enough that a wrapping counter would land on a full frame again
        build_good(-1);
        while (frame_q.size() < WRAP_LEN)
            frame_q.push_back(8'($urandom));
        send_frame(sent);
        build_body(-1);
        frame_q[1] = 8'h83;
        frame_q[2] = 8'd35;
        append_crc();
        send_frame(sent);
        build_body(-1);
        frame_q[0] ^= 8'h01;
        append_crc();
        frame_q[40] ^= 8'h01;
        send_frame(sent);
        build_good(-1);
        frame_q[39] ^= 8'h01;
        send_frame(sent);

        phase_addr[0] = 8'd0;
        phase_addr[1] = 8'd255;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = 8'd1;
        for (int p = 0; p < 4; p++)
        begin
            write_address(phase_addr[p]);
            calm = (p == 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    build_good(-1);
                end
                else if (kind < 80)
                begin
                    build_body(-1);
                    frame_q[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
                    append_crc();
                end
                else if (kind < 90)
                begin
                    build_good(-1);
                    pos = $urandom_range(0, FRAME_LEN - 1);
                    frame_q[pos] ^= 8'($urandom_range(1, 255));
                end
                else
                begin
                    len = $urandom_range(1, 80);
                    frame_q = {};
                    repeat (len) frame_q.push_back(8'($urandom));
                end
                send_frame(sent);
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("modbus_meter_response_checker_top_tb: PASS");
        else
            $display("modbus_meter_response_checker_top_tb: FAIL");
        $finish;
    end

endmodule
